>>> src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/pccs_pkg.sv
`timescale 1ns / 1ps
package pccs_pkg;
    localparam int MaxBins    = 1024;
    localparam int IdxBits    = 10;
    localparam int WeightBits = 16;
    localparam int FracBits   = 16;
    localparam int SumBits    = 26;
    localparam int DensBits   = 27;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_BUILD  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUILT    = 2'd1;
    localparam logic [1:0] ST_FALLBACK = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  bin_index;
        logic [15:0] weight;
        logic [15:0] sample_u;
    } t_in_word;

    typedef struct packed {
        logic [9:0]  chosen_bin;
        logic [15:0] position;
        logic [26:0] density;
        logic [1:0]  status;
    } t_out_word;

    // restoring divider request
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } t_div_req;
endpackage

>>> src/pccs_div.sv
`timescale 1ns / 1ps
// serial restoring divider, one quotient bit per cycle, 64 / 32
module pccs_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pccs_pkg::t_div_req   i_req,
    output logic                 o_done,
    output logic [63:0]          o_quot
);
    import pccs_pkg::*;

    logic [63:0] r_quot;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;
    logic [32:0] w_sub;

    assign w_trial = {r_rem[31:0], r_quot[63]};
    assign w_sub   = w_trial - {1'b0, r_den};

    // one step per cycle while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quot <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                if (!w_sub[32]) begin
                    r_rem  <= w_sub;
                    r_quot <= {r_quot[62:0], 1'b1};
                end else begin
                    r_rem  <= w_trial;
                    r_quot <= {r_quot[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> src/piecewise_constant_cdf_sampler_top.sv
`timescale 1ns / 1ps
// load: accepted while idle, busy stays low, no result. build: walks the weight memory,
// reading each bin's weight and then adding it into the next prefix sum, then strobes.
// sample: the fallback (no build yet or zero total) strobes without a search; otherwise
// a binary search of up to 11 steps, two prefix reads and three serial divisions.
// one word in flight at a time; results strobed for one cycle, the receiver cannot stall.
// synchronous active-low reset clears control, total, built flag and bin count (to 1).
module piecewise_constant_cdf_sampler_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  pccs_pkg::t_in_word     i_word,
    input  logic                   i_cfg_we,
    input  logic [10:0]            i_cfg_data,
    output logic                   o_valid,
    output pccs_pkg::t_out_word    o_word
);
    import pccs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_BLD_RD, S_BLD_ACC, S_SMP_RD, S_SMP_CMP,
        S_RD_LO, S_RD_HI, S_DIV_FRAC, S_DIV_POS, S_DIV_DENS, S_DONE
    } t_state;

    logic [WeightBits-1:0] weight_mem [MaxBins];
    logic [SumBits-1:0]    prefix_mem [MaxBins+1];

    t_state r_state;
    logic [10:0] r_cfg_n, r_n;
    logic [SumBits-1:0] r_total, r_acc;
    logic r_built;
    logic [10:0] r_i;
    logic [10:0] r_lo, r_hi;
    logic [41:0] r_target;
    logic [SumBits-1:0] r_plo, r_delta;
    logic [15:0] r_pos;
    logic [9:0] r_off;
    logic r_valid;
    t_out_word r_out;
    t_div_req r_dreq;
    logic w_ddone;
    logic [63:0] w_dq;

    logic [WeightBits-1:0] r_wrd;
    logic [SumBits-1:0]    r_prd;
    logic [10:0] r_prd_addr;
    logic        r_prd_re;
    logic [10:0] w_mid;
    logic [41:0] w_pscaled;
    logic [41:0] w_num;
    logic [10:0] w_lo1;

    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign w_pscaled = {r_prd, 16'd0};
    assign w_lo1 = (r_lo == 11'd0) ? 11'd0 : r_lo - 11'd1;
    assign w_num = (r_target < {r_plo, 16'd0}) ? 42'd0 : r_target - {r_plo, 16'd0};

    pccs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_dreq),
        .o_done (w_ddone),
        .o_quot (w_dq)
    );

    // weight memory: write on load, read during build
    always_ff @(posedge i_clk) begin
        if (start && !busy && i_word.op == OP_LOAD)
            weight_mem[i_word.bin_index] <= i_word.weight;
        r_wrd <= weight_mem[r_i[9:0]];
    end

    // prefix memory: written during build, read by search and the two bin-edge reads
    always_ff @(posedge i_clk) begin
        if (r_state == S_BLD_ACC)
            prefix_mem[r_i + 11'd1] <= r_acc + r_wrd;
        else if (r_state == S_BLD_RD && r_i == 11'd0)
            prefix_mem[0] <= '0;
        if (r_prd_re)
            r_prd <= prefix_mem[r_prd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg_n <= 11'd1;
            r_n     <= 11'd1;
            r_total <= '0;
            r_built <= 1'b0;
            r_valid <= 1'b0;
            r_prd_re <= 1'b0;
            r_dreq.start <= 1'b0;
        end else begin
            r_valid      <= 1'b0;
            r_dreq.start <= 1'b0;
            r_prd_re     <= 1'b0;
            if (i_cfg_we)
                r_cfg_n <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (i_word.op)
                            OP_BUILD: begin
                                r_n <= (r_cfg_n == 11'd0) ? 11'd1 :
                                       (r_cfg_n > 11'(MaxBins)) ? 11'(MaxBins) : r_cfg_n;
                                r_i   <= 11'd0;
                                r_acc <= '0;
                                r_state <= S_BLD_RD;
                            end
                            OP_SAMPLE: begin
                                if (!r_built || r_total == '0) begin
                                    r_out.chosen_bin <= 10'(({16'd0, i_word.sample_u} *
                                                        {21'd0, r_n}) >> FracBits);
                                    r_out.position <= i_word.sample_u;
                                    r_out.density  <= 27'(1 << FracBits);
                                    r_out.status   <= ST_FALLBACK;
                                    r_state <= S_DONE;
                                end else begin
                                    r_target <= 42'(i_word.sample_u) * 42'(r_total);
                                    r_lo <= 11'd0;
                                    r_hi <= r_n + 11'd1;
                                    r_state <= S_SMP_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // build: read weight i, then accumulate into prefix i+1
                S_BLD_RD: r_state <= S_BLD_ACC;
                S_BLD_ACC: begin
                    r_acc <= r_acc + r_wrd;
                    r_i   <= r_i + 11'd1;
                    if (r_i + 11'd1 == r_n) begin
                        r_total <= r_acc + r_wrd;
                        r_built <= 1'b1;
                        r_out   <= '{chosen_bin: '0, position: '0, density: '0,
                                     status: ST_BUILT};
                        r_state <= S_DONE;
                    end else
                        r_state <= S_BLD_RD;
                end
                // search: read prefix at mid, compare in S_SMP_CMP once r_prd holds the read data
                S_SMP_RD: begin
                    if (r_lo < r_hi) begin
                        r_prd_addr <= w_mid;
                        r_prd_re <= 1'b1;
                        r_state  <= S_SMP_CMP;
                    end else begin
                        r_off <= (w_lo1 > r_n - 11'd1) ? 10'(r_n - 11'd1) : 10'(w_lo1);
                        r_prd_addr <= (w_lo1 > r_n - 11'd1) ? r_n - 11'd1 : w_lo1;
                        r_prd_re <= 1'b1;
                        r_state <= S_RD_LO;
                    end
                end
                S_SMP_CMP: begin
                    if (r_prd_re) ;
                    else begin
                        if (w_pscaled < r_target) r_lo <= r_prd_addr + 11'd1;
                        else r_hi <= r_prd_addr;
                        r_state <= S_SMP_RD;
                    end
                end
                S_RD_LO: begin
                    if (!r_prd_re && r_prd_addr == {1'b0, r_off}) begin
                        r_plo <= r_prd;
                        r_prd_addr <= {1'b0, r_off} + 11'd1;
                        r_prd_re <= 1'b1;
                        r_state <= S_RD_HI;
                    end
                end
                S_RD_HI: begin
                    if (!r_prd_re) begin
                        r_delta <= r_prd - r_plo;
                        r_dreq.num <= 64'(w_num);
                        r_dreq.den <= 32'(r_prd - r_plo);
                        r_dreq.start <= 1'b1;
                        r_state <= S_DIV_FRAC;
                    end
                end
                S_DIV_FRAC: begin
                    if (w_ddone) begin
                        r_dreq.num <= {38'd0, r_off, 16'd0} +
                                      ((r_delta == '0) ? 64'd0 :
                                       (w_dq >= 64'd65536) ? 64'hFFFF : {48'd0, w_dq[15:0]});
                        r_dreq.den <= 32'(r_n);
                        r_dreq.start <= 1'b1;
                        r_state <= S_DIV_POS;
                    end
                end
                S_DIV_POS: begin
                    if (w_ddone) begin
                        r_pos <= w_dq[15:0];
                        r_dreq.num <= {11'd0, ({11'd0, r_delta} * {26'd0, r_n}), 16'd0};
                        r_dreq.den <= 32'(r_total);
                        r_dreq.start <= 1'b1;
                        r_state <= S_DIV_DENS;
                    end
                end
                S_DIV_DENS: begin
                    if (w_ddone) begin
                        r_out.chosen_bin <= r_off;
                        r_out.position   <= r_pos;
                        r_out.density    <= (w_dq > 64'(27'h7FFFFFF)) ? 27'h7FFFFFF
                                                                      : w_dq[26:0];
                        r_out.status     <= ST_OK;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_word  = r_out;
endmodule

>>> src/pccs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pccs_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input pccs_pkg::t_out_word  o_word
);
    import pccs_pkg::*;

    // a result word closes its command, so no strobe in back-to-back cycles
    `ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)
    // a strobe only after work was in progress
    `ASSERT_IMPL(a_valid_after_busy, i_clk, i_rst_n, o_valid, $past(busy))
    // status code is a defined one
    `ASSERT_IMPL(a_status_ok, i_clk, i_rst_n, o_valid, o_word.status <= ST_FALLBACK)
    // a build word carries zero density and a zero bin index
    `ASSERT_IMPL(a_build_zero, i_clk, i_rst_n, o_valid && o_word.status == ST_BUILT,
                 o_word.density == '0 && o_word.chosen_bin == '0)
endmodule

bind piecewise_constant_cdf_sampler_top pccs_checker u_pccs_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid),
    .o_word (o_word)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import pccs_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_word    i_word = '0;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_data = '0;
    logic        o_valid;
    t_out_word   o_word;

    piecewise_constant_cdf_sampler_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_word     (i_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_word     (o_word)
    );

    always #2 i_clk = ~i_clk;

    // sampler state as seen by the predictor
    logic [15:0]     weight_mem [MaxBins];
    longint unsigned prefix_mem [MaxBins + 1];
    longint unsigned total_w;
    bit              is_built;
    int unsigned     bin_reg;
    int unsigned     bins_latched;

    t_out_word expected_words [$];
    int        n_errors;
    int        n_samples;
    int        n_fallbacks;
    int        n_builds;
    bit        gaps_on = 1'b1;

    // inverse-cdf draw over the last built prefix sums
    function automatic t_out_word draw_bin(input longint unsigned u);
        t_out_word       r;
        longint unsigned n, target, lo, hi, mid, off, delta, num, frac, dens;
        n = bins_latched;
        if (!is_built || total_w == 0) begin
            off = (u * n) >> FracBits;
            if (off >= n) off = n - 1;
            r.chosen_bin = off[9:0];
            r.position   = u[15:0];
            r.density    = 27'(64'd1 << FracBits);
            r.status     = ST_FALLBACK;
            return r;
        end
        target = u * total_w;
        lo = 0;
        hi = n + 1;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if ((prefix_mem[mid] << FracBits) < target) lo = mid + 1;
            else hi = mid;
        end
        off = (lo == 0) ? 0 : lo - 1;
        if (off > n - 1) off = n - 1;
        delta = prefix_mem[off + 1] - prefix_mem[off];
        num = (target < (prefix_mem[off] << FracBits)) ? 0 :
              target - (prefix_mem[off] << FracBits);
        frac = (delta > 0) ? num / delta : 0;
        if (frac >= (64'd1 << FracBits)) frac = (64'd1 << FracBits) - 1;
        dens = ((delta * n) << FracBits) / total_w;
        if (dens > (64'd1 << DensBits) - 1) dens = (64'd1 << DensBits) - 1;
        r.chosen_bin = off[9:0];
        r.position   = 16'(((off << FracBits) + frac) / n);
        r.density    = dens[26:0];
        r.status     = ST_OK;
        return r;
    endfunction

    // update predictor on an accepted word
    task automatic apply_word(input t_in_word w);
        t_out_word   r;
        int unsigned n;
        case (w.op)
            OP_LOAD: begin
                weight_mem[w.bin_index] = w.weight;
            end
            OP_BUILD: begin
                n = (bin_reg < 1) ? 1 : (bin_reg > MaxBins) ? MaxBins : bin_reg;
                prefix_mem[0] = 0;
                for (int i = 1; i <= n; i++)
                    prefix_mem[i] = prefix_mem[i - 1] + weight_mem[i - 1];
                total_w = prefix_mem[n];
                bins_latched = n;
                is_built = 1'b1;
                r = '0;
                r.status = ST_BUILT;
                expected_words.push_back(r);
                n_builds++;
            end
            OP_SAMPLE: begin
                r = draw_bin(w.sample_u);
                if (r.status == ST_FALLBACK) n_fallbacks++;
                expected_words.push_back(r);
                n_samples++;
            end
            default: begin
            end
        endcase
    endtask

    // send one word, optionally after a random pause
    task automatic send_word(input t_in_word w);
        if (gaps_on && $urandom_range(99) < 23) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
        apply_word(w);
    endtask

    task automatic send_op(input logic [1:0] op, input int unsigned idx,
                           input int unsigned wt, input int unsigned u);
        t_in_word w;
        w.op        = op;
        w.bin_index = idx[9:0];
        w.weight    = wt[15:0];
        w.sample_u  = u[15:0];
        send_word(w);
    endtask

    // wait until every result is in and the block is quiet
    task automatic settle();
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_bins(input int unsigned v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[10:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        bin_reg = v & 11'h7FF;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result word %h", o_word);
            end else begin
                exp_w = expected_words.pop_front();
                if (o_word.chosen_bin !== exp_w.chosen_bin
                    || o_word.position !== exp_w.position
                    || o_word.density !== exp_w.density
                    || o_word.status !== exp_w.status) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp %0d/%h/%h/%0d got %0d/%h/%h/%0d",
                            exp_w.chosen_bin, exp_w.position, exp_w.density, exp_w.status,
                            o_word.chosen_bin, o_word.position, o_word.density,
                            o_word.status);
                end
            end
        end
    end

    // every bin gets a defined weight so a build never reads an unwritten entry
    task automatic test_preload();
        for (int i = 0; i < MaxBins; i++) send_op(OP_LOAD, i, 0, 0);
    endtask

    task automatic test_directed();
        // no build yet: uniform fallback
        send_op(OP_SAMPLE, 0, 0, 16'h0000);
        send_op(OP_SAMPLE, 0, 0, 16'hFFFF);
        // zero total after build with one bin
        send_op(OP_BUILD, 0, 0, 0);
        send_op(OP_SAMPLE, 0, 0, 16'h8000);
        // unused op code is ignored
        send_op(OP_RSVD, 1023, 16'hFFFF, 16'hFFFF);
        // extremes of weight and bins, zero-width first bin
        send_op(OP_LOAD, 1023, 16'hFFFF, 0);
        send_op(OP_LOAD, 1, 16'hFFFF, 0);
        write_bins(1024);
        send_op(OP_BUILD, 0, 0, 0);
        send_op(OP_SAMPLE, 0, 0, 16'h0000);
        send_op(OP_SAMPLE, 0, 0, 16'hFFFF);
        send_op(OP_SAMPLE, 0, 0, 16'h8000);
        // reload after build: sampling keeps the old prefix sums
        send_op(OP_LOAD, 1023, 16'h0001, 0);
        send_op(OP_SAMPLE, 0, 0, 16'hC000);
        // register below and above the legal range
        write_bins(0);
        send_op(OP_BUILD, 0, 0, 0);
        send_op(OP_SAMPLE, 0, 0, 16'h1234);
        write_bins(2047);
        send_op(OP_BUILD, 0, 0, 0);
        send_op(OP_SAMPLE, 0, 0, 16'h7FFF);
    endtask

    task automatic test_random();
        int unsigned n, sent;
        sent = 0;
        for (int ph = 0; sent < 250; ph++) begin
            gaps_on = !(ph >= 4 && ph < 7);
            if (ph % 9 == 8) n = $urandom_range(1, 2047);
            else if (ph % 9 == 7) n = (ph % 2) ? 1 : 1024;
            else n = $urandom_range(1, 24);
            write_bins(n);
            if (n > MaxBins) n = MaxBins;
            for (int i = 0; i < n && i < 32; i++) begin
                send_op(OP_LOAD, ($urandom_range(99) < 90) ? i : $urandom_range(1023),
                        ($urandom_range(99) < 20) ? 0 : $urandom, $urandom);
                sent++;
            end
            if ($urandom_range(99) < 10) begin
                // all-zero set exercises the fallback
                for (int i = 0; i < n && i < 32; i++) send_op(OP_LOAD, i, 0, $urandom);
            end
            send_op(OP_BUILD, $urandom, $urandom, $urandom);
            sent++;
            repeat ($urandom_range(6, 14)) begin
                case ($urandom_range(9))
                    0: send_op(OP_LOAD, $urandom, $urandom, $urandom);
                    1: send_op(OP_RSVD, $urandom, $urandom, $urandom);
                    default: send_op(OP_SAMPLE, $urandom, $urandom, $urandom);
                endcase
                sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < MaxBins; i++) weight_mem[i] = '0;
        for (int i = 0; i <= MaxBins; i++) prefix_mem[i] = 0;
        total_w = 0;
        is_built = 1'b0;
        bin_reg = 1;
        bins_latched = 1;
        n_errors = 0;
        n_samples = 0;
        n_fallbacks = 0;
        n_builds = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_preload();
        test_directed();
        test_random();
        settle();
        repeat (300) @(posedge i_clk);
        n_errors += expected_words.size();
        $display("covered %0d builds and %0d draws, %0d of them uniform fallback,",
                 n_builds, n_samples, n_fallbacks);
        $display("bin counts from one to the maximum, with and without input pauses");
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
